[hdl/clr_pkg.sv]
// shared constants, types and helpers for the cubic lagrange resampler
`default_nettype none
package clr_pkg;
    localparam int MaxKnots = 1024;
    localparam int IdxW = $clog2(MaxKnots);
    localparam int CntW = 11;
    localparam int MagW = 32;
    localparam int ProdW = 3 * MagW;
    localparam int NumW = ProdW + 16;
    localparam int MulSteps = MagW;
    localparam int DivSteps = NumW;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_ABOVE = 2'd1;
    localparam logic [1:0] ST_FEW = 2'd2;
    localparam logic [1:0] ST_ZDEN = 2'd3;

    localparam logic CFG_KNOT_COUNT = 1'b0;
    localparam logic CFG_EXTEND_MODE = 1'b1;

    typedef logic signed [32:0] diff_t;

    function automatic logic [MagW-1:0] mag33(input diff_t v);
        logic [32:0] neg_v;
        neg_v = 33'(-v);
        return v[32] ? neg_v[MagW-1:0] : v[MagW-1:0];
    endfunction

    function automatic logic [MagW-1:0] mag32(input logic signed [31:0] v);
        logic [32:0] neg_v;
        neg_v = 33'(-{v[31], v});
        return v[31] ? neg_v[MagW-1:0] : v;
    endfunction
endpackage
`default_nettype wire

[hdl/clr_mul.sv]
// shift-add multiplier, one multiplier bit per cycle
`default_nettype none
module clr_mul (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [2*clr_pkg::MagW-1:0]  a,
    input  wire logic [clr_pkg::MagW-1:0]    b,
    output logic                             done,
    output logic [clr_pkg::ProdW-1:0]        p
);
    localparam int SW = $clog2(clr_pkg::MulSteps);

    logic                       busy_reg;
    logic                       done_reg;
    logic [SW-1:0]              cnt_reg;
    logic [clr_pkg::ProdW-1:0]  mcand_reg;
    logic [clr_pkg::MagW-1:0]   mplier_reg;
    logic [clr_pkg::ProdW-1:0]  acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == SW'(clr_pkg::MulSteps - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg  <= clr_pkg::ProdW'(a);
            mplier_reg <= b;
            acc_reg    <= '0;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= {mcand_reg[clr_pkg::ProdW-2:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[clr_pkg::MagW-1:1]};
        end
    end

    assign done = done_reg;
    assign p    = acc_reg;
endmodule
`default_nettype wire

[hdl/clr_div.sv]
// restoring divider for one lagrange weight, with rounding and saturation
`default_nettype none
module clr_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [clr_pkg::NumW-1:0]    num,
    input  wire logic [clr_pkg::ProdW-1:0]   den,
    input  wire logic                        neg,
    output logic                             done,
    output logic signed [31:0]               w
);
    localparam int SW = $clog2(clr_pkg::DivSteps);
    localparam int RW = clr_pkg::ProdW + 1;

    logic                       busy_reg;
    logic                       done_reg;
    logic [SW-1:0]              cnt_reg;
    logic [clr_pkg::NumW-1:0]   num_reg;
    logic [clr_pkg::ProdW-1:0]  den_reg;
    logic [RW-1:0]              rem_reg;
    logic [32:0]                quo_reg;
    logic                       ovf_reg;
    logic                       neg_reg;

    logic [RW-1:0]  rem_sh;
    logic           ge;
    logic           round_up;
    logic [33:0]    q_fin;

    assign rem_sh = {rem_reg[RW-2:0], num_reg[clr_pkg::NumW-1]};
    assign ge     = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == SW'(clr_pkg::DivSteps - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            neg_reg <= neg;
            rem_reg <= '0;
            quo_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[clr_pkg::NumW-2:0], 1'b0};
            rem_reg <= ge ? rem_sh - {1'b0, den_reg} : rem_sh;
            quo_reg <= {quo_reg[31:0], ge};
            ovf_reg <= ovf_reg | quo_reg[32];
        end
    end

    // half away from zero on the magnitude
    assign round_up = {rem_reg, 1'b0} >= {2'b00, den_reg};
    assign q_fin    = {1'b0, quo_reg} + 34'(round_up);

    always_comb
    begin
        if (neg_reg)
        begin
            if (ovf_reg || q_fin > 34'h0_8000_0000)
            begin
                w = 32'sh8000_0000;
            end
            else
            begin
                w = 32'(-q_fin);
            end
        end
        else
        begin
            if (ovf_reg || q_fin > 34'h0_7FFF_FFFF)
            begin
                w = 32'sh7FFF_FFFF;
            end
            else
            begin
                w = q_fin[31:0];
            end
        end
    end

    assign done = done_reg;
endmodule
`default_nettype wire

[hdl/cubic_lagrange_resampler.sv]
// top level: knot stores, search pointer walk and weight sequencer
// Usage. A word is taken at a clock edge with start high and busy low.
// operation 0 writes one knot (knot_index, knot_x, knot_y) into the
// abscissa and ordinate memories in that cycle, restarts the search pointer
// and gives no result; busy stays low, so loads can follow back to back.
// operation 1 is a query (query_x, last_query): busy rises and the block
// clamps the position, walks the pointer through the abscissa memory (one
// memory read per step), reads the four-knot stencil, then forms each weight
// on a shared shift-add multiplier (four products) and a restoring divider,
// and sums the four weighted ordinates on the same multiplier; with
// extend_mode zero, a query above the last knot skips the sum. A repeated
// knot abscissa in the stencil ends the query early, and with fewer than
// four knots busy is high for the result cycle only.
// The result word shows on value and status with done high for exactly one
// cycle; busy falls in the next cycle. The receiver cannot stall.
// cfg_we writes knot_count (index 0) or extend_mode (index 1); the user must
// write them only while idle, which the block leaves unchecked. Reset clears
// the control state, sets the pointer to three, knot_count to four and
// extend_mode to one; the knot memories hold nothing until loaded.
`default_nettype none
module cubic_lagrange_resampler (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic                operation,
    input  wire logic [9:0]          knot_index,
    input  wire logic signed [31:0]  knot_x,
    input  wire logic signed [31:0]  knot_y,
    input  wire logic signed [31:0]  query_x,
    input  wire logic                last_query,
    output logic                     done,
    output logic signed [31:0]       value,
    output logic [1:0]               status,
    input  wire logic                cfg_we,
    input  wire logic                cfg_index,
    input  wire logic [10:0]         cfg_data
);
    localparam int IW = clr_pkg::IdxW;
    localparam int CW = clr_pkg::CntW;
    localparam int MW = clr_pkg::MagW;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RD_LO  = 4'd1;
    localparam logic [3:0] S_RD_HI  = 4'd2;
    localparam logic [3:0] S_CLAMP  = 4'd3;
    localparam logic [3:0] S_WALK_A = 4'd4;
    localparam logic [3:0] S_WALK_D = 4'd5;
    localparam logic [3:0] S_STEN   = 4'd6;
    localparam logic [3:0] S_CHECK  = 4'd7;
    localparam logic [3:0] S_MUL_GO = 4'd8;
    localparam logic [3:0] S_MUL_W  = 4'd9;
    localparam logic [3:0] S_DIV_GO = 4'd10;
    localparam logic [3:0] S_DIV_W  = 4'd11;
    localparam logic [3:0] S_SUM_GO = 4'd12;
    localparam logic [3:0] S_SUM_W  = 4'd13;
    localparam logic [3:0] S_FIN    = 4'd14;
    localparam logic [3:0] S_OUT    = 4'd15;

    logic signed [31:0] x_mem [clr_pkg::MaxKnots];
    logic signed [31:0] y_mem [clr_pkg::MaxKnots];
    logic signed [31:0] x_rd_reg, y_rd_reg;
    logic [IW-1:0]      rd_addr;

    logic [3:0]   state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          ext_reg, ext_next;
    logic [IW-1:0] ptr_reg, ptr_next;
    logic [IW-1:0] j_reg, j_next;
    logic signed [31:0] qx_reg, qx_next;
    logic          last_reg, last_next;
    logic signed [31:0] xlo_reg, xlo_next;
    logic signed [31:0] xx_reg, xx_next;
    logic          above_reg, above_next;
    logic [2:0]    cnt_reg, cnt_next;
    logic signed [31:0] xs_reg [4];
    logic signed [31:0] xs_next [4];
    logic signed [31:0] ys_reg [4];
    logic signed [31:0] ys_next [4];
    clr_pkg::diff_t dx_reg [4];
    clr_pkg::diff_t dx_next [4];
    logic signed [31:0] w_reg [4];
    logic signed [31:0] w_next [4];
    logic [1:0]    k_reg, k_next;
    logic [1:0]    ms_reg, ms_next;
    logic [2*MW-1:0] t_reg, t_next;
    logic [clr_pkg::ProdW-1:0] num_reg, num_next;
    logic [clr_pkg::ProdW-1:0] den_reg, den_next;
    logic signed [65:0] acc_reg, acc_next;
    logic signed [31:0] value_reg, value_next;
    logic [1:0]    status_reg, status_next;

    logic [CW-1:0] n_eff;
    logic [IW-1:0] a_base;
    clr_pkg::diff_t d12, d13, d14, d23, d34, d42;
    clr_pkg::diff_t n1, n2, n3, e1, e2, e3;
    logic          w_neg;
    logic          mul_go, mul_done;
    logic [2*MW-1:0] mul_a;
    logic [MW-1:0] mul_b;
    logic [clr_pkg::ProdW-1:0] mul_p;
    logic          div_go, div_done;
    logic signed [31:0] div_w;
    logic signed [65:0] acc_rnd;
    logic signed [49:0] acc_sh;
    logic [CW-1:0] j_clamp;

    assign n_eff  = (count_reg > CW'(clr_pkg::MaxKnots)) ? CW'(clr_pkg::MaxKnots) : count_reg;
    assign a_base = j_reg - IW'(3);

    // knot memories, one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start && operation == clr_pkg::OP_LOAD
            && 32'(knot_index) < 32'(clr_pkg::MaxKnots))
        begin
            x_mem[IW'(knot_index)] <= knot_x;
            y_mem[IW'(knot_index)] <= knot_y;
        end
        x_rd_reg <= x_mem[rd_addr];
        y_rd_reg <= y_mem[rd_addr];
    end

    always_comb
    begin
        case (state_reg)
            S_RD_HI:  rd_addr = IW'(n_eff - CW'(1));
            S_WALK_A: rd_addr = j_reg - IW'(1);
            S_STEN:   rd_addr = a_base + IW'(cnt_reg[1:0]);
            default:  rd_addr = '0;
        endcase
    end

    assign d12 = clr_pkg::diff_t'(xs_reg[0]) - clr_pkg::diff_t'(xs_reg[1]);
    assign d13 = clr_pkg::diff_t'(xs_reg[0]) - clr_pkg::diff_t'(xs_reg[2]);
    assign d14 = clr_pkg::diff_t'(xs_reg[0]) - clr_pkg::diff_t'(xs_reg[3]);
    assign d23 = clr_pkg::diff_t'(xs_reg[1]) - clr_pkg::diff_t'(xs_reg[2]);
    assign d34 = clr_pkg::diff_t'(xs_reg[2]) - clr_pkg::diff_t'(xs_reg[3]);
    assign d42 = clr_pkg::diff_t'(xs_reg[3]) - clr_pkg::diff_t'(xs_reg[1]);

    always_comb
    begin
        case (k_reg)
            2'd0:
            begin
                n1 = dx_reg[1]; n2 = dx_reg[2]; n3 = dx_reg[3];
                e1 = d12; e2 = d13; e3 = d14;
            end
            2'd1:
            begin
                n1 = dx_reg[0]; n2 = dx_reg[2]; n3 = dx_reg[3];
                e1 = d12; e2 = d23; e3 = d42;
            end
            2'd2:
            begin
                n1 = dx_reg[0]; n2 = dx_reg[1]; n3 = dx_reg[3];
                e1 = d13; e2 = d23; e3 = d34;
            end
            default:
            begin
                n1 = dx_reg[0]; n2 = dx_reg[1]; n3 = dx_reg[2];
                e1 = d14; e2 = d42; e3 = d34;
            end
        endcase
    end

    assign w_neg = n1[32] ^ n2[32] ^ n3[32] ^ e1[32] ^ e2[32] ^ e3[32];

    always_comb
    begin
        if (state_reg == S_SUM_GO)
        begin
            mul_a = (2*MW)'(clr_pkg::mag32(w_reg[k_reg]));
            mul_b = clr_pkg::mag32(ys_reg[k_reg]);
        end
        else
        begin
            case (ms_reg)
                2'd0:
                begin
                    mul_a = (2*MW)'(clr_pkg::mag33(n1));
                    mul_b = clr_pkg::mag33(n2);
                end
                2'd1:
                begin
                    mul_a = t_reg;
                    mul_b = clr_pkg::mag33(n3);
                end
                2'd2:
                begin
                    mul_a = (2*MW)'(clr_pkg::mag33(e1));
                    mul_b = clr_pkg::mag33(e2);
                end
                default:
                begin
                    mul_a = t_reg;
                    mul_b = clr_pkg::mag33(e3);
                end
            endcase
        end
    end

    assign mul_go = (state_reg == S_MUL_GO) || (state_reg == S_SUM_GO);
    assign div_go = (state_reg == S_DIV_GO);

    clr_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_go),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .p     (mul_p)
    );

    clr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_go),
        .num   ({num_reg, 16'h0000}),
        .den   (den_reg),
        .neg   (w_neg),
        .done  (div_done),
        .w     (div_w)
    );

    assign acc_rnd = acc_reg + 66'sd32768;
    assign acc_sh  = 50'(acc_rnd >>> 16);

    assign j_clamp = ({1'b0, ptr_reg} > n_eff - CW'(1)) ? n_eff - CW'(1)
                   : (({1'b0, ptr_reg} < CW'(3)) ? CW'(3) : {1'b0, ptr_reg});

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        ext_next    = ext_reg;
        ptr_next    = ptr_reg;
        j_next      = j_reg;
        qx_next     = qx_reg;
        last_next   = last_reg;
        xlo_next    = xlo_reg;
        xx_next     = xx_reg;
        above_next  = above_reg;
        cnt_next    = cnt_reg;
        xs_next     = xs_reg;
        ys_next     = ys_reg;
        dx_next     = dx_reg;
        w_next      = w_reg;
        k_next      = k_reg;
        ms_next     = ms_reg;
        t_next      = t_reg;
        num_next    = num_reg;
        den_next    = den_reg;
        acc_next    = acc_reg;
        value_next  = value_reg;
        status_next = status_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                clr_pkg::CFG_KNOT_COUNT:  count_next = cfg_data;
                clr_pkg::CFG_EXTEND_MODE: ext_next = cfg_data[0];
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (operation == clr_pkg::OP_LOAD)
                    begin
                        ptr_next = IW'(3);
                    end
                    else
                    begin
                        qx_next   = query_x;
                        last_next = last_query;
                        j_next    = ptr_reg;
                        if (n_eff < CW'(4))
                        begin
                            value_next  = '0;
                            status_next = clr_pkg::ST_FEW;
                            state_next  = S_OUT;
                        end
                        else
                        begin
                            state_next = S_RD_LO;
                        end
                    end
                end
            end
            S_RD_LO:
            begin
                state_next = S_RD_HI;
            end
            S_RD_HI:
            begin
                xlo_next   = x_rd_reg;
                state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                if (qx_reg < xlo_reg)
                begin
                    xx_next = xlo_reg;
                end
                else if (qx_reg >= x_rd_reg)
                begin
                    xx_next = x_rd_reg;
                end
                else
                begin
                    xx_next = qx_reg;
                end
                above_next = qx_reg > x_rd_reg;
                j_next     = IW'(j_clamp);
                state_next = S_WALK_A;
            end
            S_WALK_A:
            begin
                state_next = S_WALK_D;
            end
            S_WALK_D:
            begin
                if (xx_reg > x_rd_reg && {1'b0, j_reg} < n_eff - CW'(1))
                begin
                    j_next     = j_reg + IW'(1);
                    state_next = S_WALK_A;
                end
                else
                begin
                    cnt_next   = '0;
                    state_next = S_STEN;
                end
            end
            S_STEN:
            begin
                // read data belongs to the address given in the cycle before
                if (cnt_reg != 3'd0)
                begin
                    xs_next[cnt_reg[1:0] - 2'd1] = x_rd_reg;
                    ys_next[cnt_reg[1:0] - 2'd1] = y_rd_reg;
                    dx_next[cnt_reg[1:0] - 2'd1] =
                        clr_pkg::diff_t'(xx_reg) - clr_pkg::diff_t'(x_rd_reg);
                end
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd4)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (d12 == '0 || d13 == '0 || d14 == '0 || d23 == '0 || d34 == '0
                    || d42 == '0)
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        w_next[i] = '0;
                    end
                    value_next  = '0;
                    status_next = clr_pkg::ST_ZDEN;
                    state_next  = S_OUT;
                end
                else
                begin
                    k_next     = 2'd0;
                    ms_next    = 2'd0;
                    state_next = S_MUL_GO;
                end
            end
            S_MUL_GO:
            begin
                state_next = S_MUL_W;
            end
            S_MUL_W:
            begin
                if (mul_done)
                begin
                    case (ms_reg)
                        2'd1:    num_next = mul_p;
                        2'd3:    den_next = mul_p;
                        default: t_next = mul_p[2*MW-1:0];
                    endcase
                    ms_next    = ms_reg + 2'd1;
                    state_next = (ms_reg == 2'd3) ? S_DIV_GO : S_MUL_GO;
                end
            end
            S_DIV_GO:
            begin
                state_next = S_DIV_W;
            end
            S_DIV_W:
            begin
                if (div_done)
                begin
                    w_next[k_reg] = div_w;
                    k_next        = k_reg + 2'd1;
                    if (k_reg != 2'd3)
                    begin
                        state_next = S_MUL_GO;
                    end
                    else if (!ext_reg && above_reg)
                    begin
                        value_next  = '0;
                        status_next = clr_pkg::ST_ABOVE;
                        state_next  = S_OUT;
                    end
                    else
                    begin
                        acc_next   = '0;
                        state_next = S_SUM_GO;
                    end
                end
            end
            S_SUM_GO:
            begin
                state_next = S_SUM_W;
            end
            S_SUM_W:
            begin
                if (mul_done)
                begin
                    if (w_reg[k_reg][31] ^ ys_reg[k_reg][31])
                    begin
                        acc_next = acc_reg - 66'($signed({1'b0, mul_p[63:0]}));
                    end
                    else
                    begin
                        acc_next = acc_reg + 66'($signed({1'b0, mul_p[63:0]}));
                    end
                    k_next     = k_reg + 2'd1;
                    state_next = (k_reg == 2'd3) ? S_FIN : S_SUM_GO;
                end
            end
            S_FIN:
            begin
                if (acc_sh > 50'sh7FFF_FFFF)
                begin
                    value_next = 32'sh7FFF_FFFF;
                end
                else if (acc_sh < -50'sh8000_0000)
                begin
                    value_next = 32'sh8000_0000;
                end
                else
                begin
                    value_next = acc_sh[31:0];
                end
                status_next = clr_pkg::ST_OK;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                ptr_next   = last_reg ? IW'(3) : j_reg;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= CW'(4);
            ext_reg   <= 1'b1;
            ptr_reg   <= IW'(3);
            for (int i = 0; i < 4; i++)
            begin
                w_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ext_reg   <= ext_next;
            ptr_reg   <= ptr_next;
            w_reg     <= w_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg      <= j_next;
        qx_reg     <= qx_next;
        last_reg   <= last_next;
        xlo_reg    <= xlo_next;
        xx_reg     <= xx_next;
        above_reg  <= above_next;
        cnt_reg    <= cnt_next;
        xs_reg     <= xs_next;
        ys_reg     <= ys_next;
        dx_reg     <= dx_next;
        k_reg      <= k_next;
        ms_reg     <= ms_next;
        t_reg      <= t_next;
        num_reg    <= num_next;
        den_reg    <= den_next;
        acc_reg    <= acc_next;
        value_reg  <= value_next;
        status_reg <= status_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = (state_reg == S_OUT);
    assign value  = value_reg;
    assign status = status_reg;
endmodule
`default_nettype wire

[hdl/clr_checker.sv]
// port-level checks for the resampler, bound to the top level
`default_nettype none
module clr_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        operation,
    input wire logic        done
);
    a_done_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result word outside a busy query");

    a_done_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy && !done)
        else $error("block not idle after result word");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && operation == clr_pkg::OP_QUERY |=> busy)
        else $error("query accepted without going busy");

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && operation == clr_pkg::OP_LOAD |=> !busy && !done)
        else $error("knot load disturbed the idle state");
endmodule

bind cubic_lagrange_resampler clr_checker u_clr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .operation (operation),
    .done      (done)
);
`default_nettype wire
